FILE: hdl/hsv2rgb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Widths, range limits, scaling constants and the hue sector type that the
// converter modules and channel interfaces share.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int IN_W     = 16;
  localparam int HUE_W    = 13;
  localparam int PCT_W    = 11;
  localparam int K_W      = 10;
  localparam int SV_W     = 2 * PCT_W;
  localparam int NUM_W    = 32;
  localparam int BYTE_W   = 8;

  localparam int HUE_MAX      = 5760;
  localparam int PCT_MAX      = 1600;
  localparam int SECTOR_UNITS = 960;

  // The common denominator is 2^18 * 9375. The power of two is a shift, and
  // the odd part is a multiply by a rounded-up reciprocal of 2^36 / 9375.
  localparam int DENOM_SHIFT  = 18;
  localparam int DENOM_ODD    = 9375;
  localparam int P_W          = 22;
  localparam int RECIP_SHIFT  = 36;
  localparam int RECIP_W      = 23;
  localparam logic [RECIP_W-1:0] RECIP_M = 23'd7330078;

  typedef enum logic [2:0] {
    SEC_RED_GREEN_UP   = 3'd0,
    SEC_GREEN_RED_DOWN = 3'd1,
    SEC_GREEN_BLUE_UP  = 3'd2,
    SEC_BLUE_GREEN_DOWN = 3'd3,
    SEC_BLUE_RED_UP    = 3'd4,
    SEC_RED_BLUE_DOWN  = 3'd5
  } sector_t;

endpackage

FILE: hdl/hsv2rgb_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV input channel
// Valid/ready channel that carries one hue, saturation and value item.
// ----------------------------------------------------------------------------
interface hsv2rgb_in_if import hsv2rgb_pkg::*; ();

  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] hue_in;
  logic signed [IN_W-1:0] saturation_in;
  logic signed [IN_W-1:0] brightness_in;

  modport source (output valid, output hue_in, output saturation_in,
                  output brightness_in, input ready);
  modport sink (input valid, input hue_in, input saturation_in,
                input brightness_in, output ready);

endinterface

FILE: hdl/hsv2rgb_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB output channel
// Valid/ready channel that carries one red, green and blue item.
// ----------------------------------------------------------------------------
interface hsv2rgb_out_if import hsv2rgb_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] red;
  logic [BYTE_W-1:0] green;
  logic [BYTE_W-1:0] blue;

  modport source (output valid, output red, output green, output blue,
                  input ready);
  modport sink (input valid, input red, input green, input blue,
                output ready);

endinterface

FILE: hdl/hsv2rgb_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB byte scaler
// Three-stage pipeline that turns a numerator over the common denominator
// into floor(numerator * 255 / denominator) without a divider.
// ----------------------------------------------------------------------------
module hsv2rgb_scale import hsv2rgb_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [NUM_W-1:0]  num,
  output logic [BYTE_W-1:0] level
);

  localparam int WIDE_W = NUM_W + BYTE_W;
  localparam int PROD_W = P_W + RECIP_W;

  logic [WIDE_W-1:0] times255;
  logic [P_W-1:0]    part;
  logic [PROD_W-1:0] prod;

  assign times255 = {num, {BYTE_W{1'b0}}} - {{BYTE_W{1'b0}}, num};

  always_ff @(posedge clk) begin
    if (en) begin
      part  <= times255[DENOM_SHIFT +: P_W];
      prod  <= {{RECIP_W{1'b0}}, part} * {{P_W{1'b0}}, RECIP_M};
      level <= prod[RECIP_SHIFT +: BYTE_W];
    end
  end

endmodule

FILE: hdl/hsv_to_rgb_converter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Converts one hue, saturation and value item into 8-bit red, green and blue
// intensities by the hexcone scheme, with exact fixed-point arithmetic.
//
// The converter is a seven-stage pipeline that accepts one item in every
// clock cycle while the output side is not stalled. Inputs are clamped to
// 0 to 360 degrees and 0 to 100 percent, a hue of exactly 360 degrees falls
// into the last sector, and each channel is (channel + m) * 255 rounded
// down. A stall on the output holds the whole pipeline, and input ready
// follows the output side in the same cycle, so throughput is set only by
// the consumer.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_top import hsv2rgb_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  hsv2rgb_in_if.sink    hsv,
  hsv2rgb_out_if.source rgb
);

  localparam int STAGES = 7;

  logic [STAGES-1:0] vld;
  logic              en;

  logic [HUE_W-1:0] h1;
  logic [PCT_W-1:0] s1;
  logic [PCT_W-1:0] v1;

  logic [SV_W-1:0] sv2;
  logic [SV_W-1:0] a2;
  logic [K_W-1:0]  k2;
  sector_t         sect2;

  logic [NUM_W-1:0] svk3;
  logic [SV_W-1:0]  a3;
  logic [SV_W-1:0]  b3;
  sector_t          sect3;

  logic [NUM_W-1:0] nr4;
  logic [NUM_W-1:0] ng4;
  logic [NUM_W-1:0] nb4;

  logic [HUE_W-1:0] h_next;
  logic [PCT_W-1:0] s_next;
  logic [PCT_W-1:0] v_next;

  sector_t          sect_next;
  logic [HUE_W-1:0] base;
  logic [HUE_W-1:0] offset;
  logic [K_W-1:0]   k_next;

  logic [NUM_W-1:0] n_hi;
  logic [NUM_W-1:0] n_mid;
  logic [NUM_W-1:0] n_lo;
  logic [NUM_W-1:0] nr_next;
  logic [NUM_W-1:0] ng_next;
  logic [NUM_W-1:0] nb_next;

  assign en        = !vld[STAGES-1] || rgb.ready;
  assign hsv.ready = en;
  assign rgb.valid = vld[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], hsv.valid};
    end
  end

  always_comb begin
    if (hsv.hue_in < 0) begin
      h_next = '0;
    end else if (hsv.hue_in > IN_W'(HUE_MAX)) begin
      h_next = HUE_W'(HUE_MAX);
    end else begin
      h_next = hsv.hue_in[HUE_W-1:0];
    end
    if (hsv.saturation_in < 0) begin
      s_next = '0;
    end else if (hsv.saturation_in > IN_W'(PCT_MAX)) begin
      s_next = PCT_W'(PCT_MAX);
    end else begin
      s_next = hsv.saturation_in[PCT_W-1:0];
    end
    if (hsv.brightness_in < 0) begin
      v_next = '0;
    end else if (hsv.brightness_in > IN_W'(PCT_MAX)) begin
      v_next = PCT_W'(PCT_MAX);
    end else begin
      v_next = hsv.brightness_in[PCT_W-1:0];
    end
  end

  always_comb begin
    if (h1 < HUE_W'(SECTOR_UNITS)) begin
      sect_next = SEC_RED_GREEN_UP;
      base      = '0;
    end else if (h1 < HUE_W'(2 * SECTOR_UNITS)) begin
      sect_next = SEC_GREEN_RED_DOWN;
      base      = HUE_W'(SECTOR_UNITS);
    end else if (h1 < HUE_W'(3 * SECTOR_UNITS)) begin
      sect_next = SEC_GREEN_BLUE_UP;
      base      = HUE_W'(2 * SECTOR_UNITS);
    end else if (h1 < HUE_W'(4 * SECTOR_UNITS)) begin
      sect_next = SEC_BLUE_GREEN_DOWN;
      base      = HUE_W'(3 * SECTOR_UNITS);
    end else if (h1 < HUE_W'(5 * SECTOR_UNITS)) begin
      sect_next = SEC_BLUE_RED_UP;
      base      = HUE_W'(4 * SECTOR_UNITS);
    end else begin
      sect_next = SEC_RED_BLUE_DOWN;
      base      = HUE_W'(5 * SECTOR_UNITS);
    end
    offset = h1 - base;
    // In odd sectors the secondary channel falls from full to zero.
    if (sect_next[0]) begin
      k_next = K_W'(SECTOR_UNITS) - offset[K_W-1:0];
    end else begin
      k_next = offset[K_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h1 <= h_next;
      s1 <= s_next;
      v1 <= v_next;

      sv2   <= {{PCT_W{1'b0}}, s1} * {{PCT_W{1'b0}}, v1};
      a2    <= {{PCT_W{1'b0}}, v1} * SV_W'(PCT_MAX);
      k2    <= k_next;
      sect2 <= sect_next;

      svk3  <= {{(NUM_W-SV_W){1'b0}}, sv2} * {{(NUM_W-K_W){1'b0}}, k2};
      a3    <= a2;
      b3    <= a2 - sv2;
      sect3 <= sect2;

      nr4 <= nr_next;
      ng4 <= ng_next;
      nb4 <= nb_next;
    end
  end

  always_comb begin
    n_hi  = {{(NUM_W-SV_W){1'b0}}, a3} * NUM_W'(SECTOR_UNITS);
    n_lo  = {{(NUM_W-SV_W){1'b0}}, b3} * NUM_W'(SECTOR_UNITS);
    n_mid = svk3 + n_lo;
    unique case (sect3)
      SEC_RED_GREEN_UP: begin
        nr_next = n_hi;
        ng_next = n_mid;
        nb_next = n_lo;
      end
      SEC_GREEN_RED_DOWN: begin
        nr_next = n_mid;
        ng_next = n_hi;
        nb_next = n_lo;
      end
      SEC_GREEN_BLUE_UP: begin
        nr_next = n_lo;
        ng_next = n_hi;
        nb_next = n_mid;
      end
      SEC_BLUE_GREEN_DOWN: begin
        nr_next = n_lo;
        ng_next = n_mid;
        nb_next = n_hi;
      end
      SEC_BLUE_RED_UP: begin
        nr_next = n_mid;
        ng_next = n_lo;
        nb_next = n_hi;
      end
      default: begin
        nr_next = n_hi;
        ng_next = n_lo;
        nb_next = n_mid;
      end
    endcase
  end

  hsv2rgb_scale u_scale_red (
    .clk   (clk),
    .en    (en),
    .num   (nr4),
    .level (rgb.red)
  );

  hsv2rgb_scale u_scale_green (
    .clk   (clk),
    .en    (en),
    .num   (ng4),
    .level (rgb.green)
  );

  hsv2rgb_scale u_scale_blue (
    .clk   (clk),
    .en    (en),
    .num   (nb4),
    .level (rgb.blue)
  );

`ifndef SYNTH
  a_valid_advance: assert property (@(posedge clk) disable iff (rst)
    (en && vld[0]) |=> vld[1])
    else $error("An item was lost between the clamp and product stages.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(sv2) && $stable(nr4) && $stable(vld)))
    else $error("Pipeline contents changed during a stall.");

  a_sector_range: assert property (@(posedge clk) disable iff (rst)
    vld[1] |-> (k2 <= K_W'(SECTOR_UNITS) && sv2 <= a2))
    else $error("Sector fraction or chroma out of range.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rgb.valid)
    else $error("Output valid after reset.");
`endif

endmodule
